FILE: rtl/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg: shared types and constants of the bitmap entry allocator
// Command and status codes, channel payload types and width helpers.
// ----------------------------------------------------------------------------
package bea_pkg;

  localparam int NUM_ENTRIES_DEF = 4096;
  localparam int WORD_BITS_DEF   = 32;

  localparam int LIMIT_W  = 13;
  localparam int INDEX_W  = 12;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  result_index;
    logic                entry_free;
  } rsp_t;

  typedef logic [LIMIT_W-1:0] cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
    rsp_t result;
  } ctrl_stat_t;

  // width of an entry counter that holds the store size plus one word
  function automatic int cnt_width(input int entries, input int word_bits);
    return $clog2(entries + word_bits + 1);
  endfunction

endpackage

FILE: rtl/bea_chan_if.sv
// ----------------------------------------------------------------------------
// bea_chan_if: valid/ready channel
// Carries one payload beat per handshake from source to sink.
// ----------------------------------------------------------------------------
interface bea_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/bea_ram.sv
// ----------------------------------------------------------------------------
// bea_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bea_find.sv
// ----------------------------------------------------------------------------
// bea_find: first-free search over one bitmap word
// Finds the lowest clear bit among the bits below the remaining limit.
// ----------------------------------------------------------------------------
module bea_find #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 13
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [CNT_W-1:0]             rem,
  output logic                         hit,
  output logic [$clog2(WORD_BITS)-1:0] pos
);

  localparam int BIT_W = $clog2(WORD_BITS);

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i] && (CNT_W'(i) < rem)) begin
        hit = 1'b1;
        pos = BIT_W'(i);
      end
    end
  end

endmodule

FILE: rtl/bea_ctrl.sv
// ----------------------------------------------------------------------------
// bea_ctrl: allocator sequencer
// Clears the bitmap after reset, then walks bitmap words one per cycle to
// allocate, free or test an entry.
// ----------------------------------------------------------------------------
module bea_ctrl import bea_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        start,
  input  req_t                                        req_data,
  input  logic [cnt_width(NUM_ENTRIES, WORD_BITS)-1:0] limit,
  input  logic                                        rsp_free,
  output ctrl_stat_t                                  stat
);

  localparam int WORD_COUNT = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CNT_W      = cnt_width(NUM_ENTRIES, WORD_BITS);
  localparam int CMP_W      = CNT_W > INDEX_W ? CNT_W : INDEX_W;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_SEEK   = 6'b001000,
    S_ACCESS = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [ADDR_W-1:0]    waddr, waddr_next;
  logic [CNT_W-1:0]     base, base_next;
  logic [CMD_W-1:0]     cmd, cmd_next;
  logic [INDEX_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]     lim, lim_next;
  rsp_t                 result, result_next;

  logic [CNT_W-1:0]     base_step;
  logic [CNT_W-1:0]     rem;
  logic [CMP_W-1:0]     idx_ext;
  logic [CMP_W-1:0]     off;
  logic [BIT_W-1:0]     bit_pos;
  logic                 word_found;
  logic                 start_in_range;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 hit;
  logic [BIT_W-1:0]     hit_pos;

  bea_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bea_find #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_find (
    .word (ram_rdata),
    .rem  (rem),
    .hit  (hit),
    .pos  (hit_pos)
  );

  assign base_step      = base + CNT_W'(WORD_BITS);
  assign rem            = lim - base;
  assign idx_ext        = CMP_W'(idx);
  assign off            = idx_ext - CMP_W'(base);
  assign bit_pos        = off[BIT_W-1:0];
  assign word_found     = idx_ext < CMP_W'(base_step);
  assign start_in_range = CMP_W'(req_data.entry_index) < CMP_W'(limit);

  always_comb begin
    state_next  = state;
    waddr_next  = waddr;
    base_next   = base;
    cmd_next    = cmd;
    idx_next    = idx;
    lim_next    = lim;
    result_next = result;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    ram_raddr   = waddr;

    case (state)
      S_CLEAR: begin
        ram_we     = 1'b1;
        waddr_next = waddr + 1'b1;
        if (waddr == ADDR_W'(WORD_COUNT - 1)) begin
          waddr_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          cmd_next    = req_data.command;
          idx_next    = req_data.entry_index;
          lim_next    = limit;
          waddr_next  = '0;
          base_next   = '0;
          result_next = '{status: STAT_RANGE, result_index: '0, entry_free: 1'b0};
          if (req_data.command == CMD_ALLOC) begin
            if (limit == '0) begin
              result_next.status = STAT_FULL;
              state_next         = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end else if ((req_data.command == CMD_FREE || req_data.command == CMD_TEST)
                       && start_in_range) begin
            state_next = S_SEEK;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = waddr + 1'b1;
        if (hit) begin
          ram_we                   = 1'b1;
          ram_wdata                = ram_rdata | (WORD_BITS'(1) << hit_pos);
          result_next.status       = STAT_OK;
          result_next.result_index = INDEX_W'(base + CNT_W'(hit_pos));
          state_next               = S_RESP;
        end else if (base_step >= lim) begin
          result_next.status = STAT_FULL;
          state_next         = S_RESP;
        end else begin
          waddr_next = waddr + 1'b1;
          base_next  = base_step;
        end
      end
      S_SEEK: begin
        if (word_found) begin
          state_next = S_ACCESS;
        end else begin
          waddr_next = waddr + 1'b1;
          base_next  = base_step;
        end
      end
      S_ACCESS: begin
        result_next.status = STAT_OK;
        if (cmd == CMD_FREE) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_pos);
        end else begin
          result_next.entry_free = ~ram_rdata[bit_pos];
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      waddr <= '0;
    end else begin
      state <= state_next;
      waddr <= waddr_next;
    end
  end

  always_ff @(posedge clk) begin
    base   <= base_next;
    cmd    <= cmd_next;
    idx    <= idx_next;
    lim    <= lim_next;
    result <= result_next;
  end

  assign stat.idle   = (state == S_IDLE);
  assign stat.done   = (state == S_RESP) && rsp_free;
  assign stat.result = result;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("request taken while busy");

  a_scan_below_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> base < lim)
    else $error("scan word beyond limit");

  a_seek_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SEEK |-> idx_ext >= CMP_W'(base))
    else $error("seek passed target word");

  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> $countones(ram_wdata) == $countones(ram_rdata) + 1)
    else $error("allocation must set exactly one bit");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> state == S_IDLE)
    else $error("sequencer did not return to idle");

endmodule

FILE: rtl/bitmap_entry_allocator_top.sv
// Allocate scans bitmap words from word 0 until it finds a free bit below the
//   limit or reaches the limit (up to NUM_ENTRIES / WORD_BITS words, 128 by default).
// In-range free and test seek the entry's word, then clear or read its bit; others respond directly.
// One request at a time, set by the one-word-per-cycle bitmap RAM walk.
// Reset: limit returns to 4096; a clearing pass over the NUM_ENTRIES / WORD_BITS
//   bitmap words (128 by default) zeroes the bitmap while req.ready stays low.
// ----------------------------------------------------------------------------
// bitmap_entry_allocator_top: first-fit bitmap entry allocator
// Holds the entry limit register and the response register around the
// word-serial allocator sequencer.
// ----------------------------------------------------------------------------
module bitmap_entry_allocator_top import bea_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bea_chan_if.sink      req,
  bea_chan_if.source    rsp,
  bea_chan_if.sink      cfg
);

  localparam int CNT_W = cnt_width(NUM_ENTRIES, WORD_BITS);
  localparam int LIM_W = CNT_W > LIMIT_W ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0] entry_limit;
  logic [LIM_W-1:0]   lim_ext;
  logic [CNT_W-1:0]   lim_eff;
  logic               start;
  logic               rsp_free;
  logic               rsp_valid;
  rsp_t               rsp_data;
  req_t               req_data;
  ctrl_stat_t         stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      entry_limit <= LIMIT_W'(cfg.payload);
    end
  end

  assign lim_ext = LIM_W'(entry_limit);
  assign lim_eff = (lim_ext > LIM_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES) : CNT_W'(lim_ext);

  assign req_data.command     = CMD_W'(req.payload.command);
  assign req_data.entry_index = INDEX_W'(req.payload.entry_index);
  assign req.ready            = stat.idle;
  assign start                = req.valid && stat.idle;
  assign rsp_free             = !rsp_valid || rsp.ready;

  bea_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_data (req_data),
    .limit    (lim_eff),
    .rsp_free (rsp_free),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stat.done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      rsp_data <= stat.result;
    end
  end

  assign rsp.valid                = rsp_valid;
  assign rsp.payload.status       = rsp_data.status;
  assign rsp.payload.result_index = rsp_data.result_index;
  assign rsp.payload.entry_free   = rsp_data.entry_free;

endmodule

FILE: sim/bitmap_entry_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_entry_allocator_checker: response checker for the entry allocator
// Watches the request, response and limit channels, keeps its own copy of
// the usage bitmap and the limit, works out the response of each accepted
// request and compares each response beat field by field in order.
// ----------------------------------------------------------------------------
module bitmap_entry_allocator_checker import bea_pkg::*; (
  input  logic clk,
  input  logic rst,
  bea_chan_if  req_mon,
  bea_chan_if  rsp_mon,
  bea_chan_if  cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  logic [NUM_ENTRIES_DEF-1:0] used_map;
  cfg_t                       entry_limit;
  rsp_t                       expected_rsp[$];
  int                         mismatch_total = 0;
  int                         queued_total = 0;

  assign fail_count  = mismatch_total;
  assign outstanding = queued_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic rsp_t serve_request(input req_t item);
    int   span;
    rsp_t out;
    span = (int'(entry_limit) > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(entry_limit);
    out = '0;
    out.status = STAT_RANGE;
    case (item.command)
      CMD_ALLOC: begin
        out.status = STAT_FULL;
        for (int e = 0; e < span; e++) begin
          if (!used_map[e]) begin
            used_map[e] = 1'b1;
            out.status = STAT_OK;
            out.result_index = e[INDEX_W-1:0];
            break;
          end
        end
      end
      CMD_FREE: begin
        if (int'(item.entry_index) < span) begin
          used_map[item.entry_index] = 1'b0;
          out.status = STAT_OK;
        end
      end
      CMD_TEST: begin
        if (int'(item.entry_index) < span) begin
          out.status = STAT_OK;
          out.entry_free = !used_map[item.entry_index];
        end
      end
      default: ;
    endcase
    return out;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t got;
    if (rst) begin
      used_map = '0;
      entry_limit = LIMIT_RESET;
      expected_rsp.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        entry_limit = cfg_mon.payload;
      if (req_mon.valid && req_mon.ready)
        expected_rsp.push_back(serve_request(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response beat with no request waiting (status %0d)",
                                    got.status));
        end else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("field status got %0d want %0d",
                                      got.status, want.status));
          if (got.result_index !== want.result_index)
            report_mismatch($sformatf("field result_index got %0d want %0d",
                                      got.result_index, want.result_index));
          if (got.entry_free !== want.entry_free)
            report_mismatch($sformatf("field entry_free got %0d want %0d",
                                      got.entry_free, want.entry_free));
        end
      end
    end
    queued_total = expected_rsp.size();
  end

endmodule

FILE: sim/bitmap_entry_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_entry_allocator_top_test: testbench of the bitmap entry allocator
// Drives directed and random allocate, free and test requests under a range
// of entry limits, with random gaps on the request side and random stalls on
// the response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module bitmap_entry_allocator_top_test;
  import bea_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 150;

  logic clk;
  logic rst;
  logic calm;
  int   fail_count;
  int   outstanding;
  int   alloc_issued;

  bea_chan_if #(.payload_t(req_t)) req_ch ();
  bea_chan_if #(.payload_t(rsp_t)) rsp_ch ();
  bea_chan_if #(.payload_t(cfg_t)) cfg_ch ();

  bitmap_entry_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  bitmap_entry_allocator_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic push_req(input logic [CMD_W-1:0] cmd, input int idx);
    req_t item;
    item.command = cmd;
    item.entry_index = idx[INDEX_W-1:0];
    while (!calm && $urandom_range(99) < 13) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= item;
    if (cmd == CMD_ALLOC)
      alloc_issued++;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // hold off requests until every response beat is back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_limit(input cfg_t value);
    drain_responses();
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t value, input int count, input int alloc_pct);
    int span;
    int hot;
    int idx;
    int pick;
    logic [CMD_W-1:0] cmd;
    write_limit(value);
    span = (int'(value) > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(value);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < alloc_pct) begin
        cmd = CMD_ALLOC;
      end else begin
        pick = $urandom_range(99);
        cmd = (pick < 48) ? CMD_FREE : (pick < 96) ? CMD_TEST : CMD_UNKNOWN;
      end
      hot = (alloc_issued + 8 < span) ? alloc_issued + 8 : span;
      pick = $urandom_range(99);
      if (span > 0 && pick < 55)
        idx = $urandom_range(hot - 1, 0);
      else if (span > 0 && pick < 85)
        idx = $urandom_range(span - 1, 0);
      else
        idx = $urandom_range(NUM_ENTRIES_DEF - 1, 0);
      push_req(cmd, idx);
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    alloc_issued = 0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_req(CMD_TEST, 0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 4095);
    push_req(CMD_TEST, 1);
    push_req(CMD_FREE, 1);
    push_req(CMD_TEST, 1);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 4095);
    push_req(CMD_TEST, 4095);
    push_req(CMD_FREE, 4095);
    push_req(CMD_UNKNOWN, 4095);
    push_req(CMD_TEST, 12'hAAA);
    push_req(CMD_TEST, 12'h555);
    write_limit(13'd0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 0);
    push_req(CMD_TEST, 0);
    write_limit(13'd3);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_TEST, 3);
    push_req(CMD_FREE, 3);
    push_req(CMD_TEST, 2);
    write_limit(13'h1FFF);
    push_req(CMD_FREE, 4095);
    push_req(CMD_TEST, 4095);
    write_limit(13'd1);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_TEST, 0);

    run_phase(13'd4096, 200, 60);
    run_phase(13'd40, 120, 50);
    run_phase(13'd1, 40, 40);
    run_phase(13'd300, 400, 80);
    calm = 1'b1;
    run_phase(13'h1FFF, 150, 50);
    drain_responses();
    calm = 1'b0;
    run_phase(13'd0, 30, 40);
    run_phase(13'd97, 150, 45);
    run_phase(13'd4095, 120, 50);
    run_phase(13'd4096, 250, 70);
    run_phase(cfg_t'($urandom_range(4096, 1)), 150, 50);
    run_phase(13'd33, 100, 50);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
